@@ rtl/core/jsu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the JSON string decoder.
// No dependencies; every other file refers to it by scoped names.
package jsu_pkg;

   localparam int RUN_MAX = 6;
   localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_STR      = 3'd1,
      MODE_ESC      = 3'd2,
      MODE_HEX      = 3'd3,
      MODE_HELD     = 3'd4,
      MODE_HELD_ESC = 3'd5,
      MODE_HELD_HEX = 3'd6
   } mode_type;

   localparam logic [1:0] STATUS_BYTE  = 2'd0;
   localparam logic [1:0] STATUS_DONE  = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;

   localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
   localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;
   localparam logic [20:0] TWO_BYTE_MIN  = 21'h80;
   localparam logic [20:0] THREE_BYTE_MIN = 21'h800;

   // One UTF-8 sequence of one to four bytes, first byte in slot 0.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } utf8_type;

   // All results caused by one input item, in order.
   typedef struct packed {
      logic [RUN_MAX-1:0][7:0] data;
      logic [RUN_MAX-1:0][1:0] status;
      logic [RUN_CNT_W-1:0]    count;
   } run_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] value;
   } esc_type;

   function automatic hex_type hex_value(logic [7:0] c);
      hex_type r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.valid = 1'b1;
         r.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r.valid = 1'b1;
         r.value = c[3:0] + 4'd9;
      end
      return r;
   endfunction

   function automatic esc_type simple_escape(logic [7:0] c);
      esc_type r;
      r.valid = 1'b1;
      unique case (c)
         CHAR_N:      r.value = 8'h0A;
         CHAR_T:      r.value = 8'h09;
         CHAR_R:      r.value = 8'h0D;
         CHAR_B:      r.value = 8'h08;
         CHAR_F:      r.value = 8'h0C;
         CHAR_SLASH:  r.value = CHAR_SLASH;
         CHAR_QUOTE:  r.value = CHAR_QUOTE;
         CHAR_BSLASH: r.value = CHAR_BSLASH;
         default: begin
            r.valid = 1'b0;
            r.value = 8'h00;
         end
      endcase
      return r;
   endfunction

   function automatic utf8_type encode_cp(logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp < TWO_BYTE_MIN) begin
         r.len      = 3'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp < THREE_BYTE_MIN) begin
         r.len      = 3'd2;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < SUPP_BASE) begin
         r.len      = 3'd3;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         r.len      = 3'd4;
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

endpackage

@@ rtl/core/jsu_front.sv @@
`timescale 1ns / 1ps
// Front end of the JSON string decoder: string state machine, hex gathering
// and surrogate joining. Turns each accepted byte into at most one run of results. Uses jsu_pkg.
module jsu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [7:0]         in_byte,
   input  logic               in_end,
   output logic               run_valid,
   output jsu_pkg::run_type   run,
   output jsu_pkg::mode_type  mode
);

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [15:0]       acc_ff, acc_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [15:0]       held_ff, held_in;

   jsu_pkg::hex_type  hex;
   jsu_pkg::esc_type  esc;
   logic [15:0]       acc_new;
   logic              hex_last;
   logic              unit_high;
   logic              unit_low;
   logic              mode_active;
   logic [20:0]       pair_cp;
   jsu_pkg::utf8_type held_enc;
   jsu_pkg::utf8_type unit_enc;
   jsu_pkg::utf8_type pair_enc;
   jsu_pkg::utf8_type byte_enc;
   jsu_pkg::utf8_type esc_enc;

   // Appends a UTF-8 sequence behind the results already in the run.
   function automatic jsu_pkg::run_type append_seq(jsu_pkg::run_type r,
                                                     jsu_pkg::utf8_type s);
      logic [2:0] off;
      for (int j = 0; j < jsu_pkg::RUN_MAX; j++) begin
         off = 3'(j) - r.count;
         if (3'(j) >= r.count && off < s.len) begin
            r.data[j]   = s.bytes[off[1:0]];
            r.status[j] = jsu_pkg::STATUS_BYTE;
         end
      end
      r.count = r.count + s.len;
      return r;
   endfunction

   function automatic jsu_pkg::utf8_type one_byte(logic [7:0] b);
      jsu_pkg::utf8_type s;
      s          = '0;
      s.len      = 3'd1;
      s.bytes[0] = b;
      return s;
   endfunction

   assign hex       = jsu_pkg::hex_value(in_byte);
   assign esc       = jsu_pkg::simple_escape(in_byte);
   assign acc_new   = {acc_ff[11:0], hex.value};
   assign hex_last  = (cnt_ff == 2'd3);
   assign unit_high = (acc_new >= jsu_pkg::HIGH_SURR_MIN) && (acc_new <= jsu_pkg::HIGH_SURR_MAX);
   assign unit_low  = (acc_new >= jsu_pkg::LOW_SURR_MIN) && (acc_new <= jsu_pkg::LOW_SURR_MAX);
   assign mode_active = (mode_ff != jsu_pkg::MODE_IDLE) && (mode_ff <= jsu_pkg::MODE_HELD_HEX);
   assign pair_cp   = jsu_pkg::SUPP_BASE + {1'b0, held_ff[9:0], acc_new[9:0]};
   assign held_enc  = jsu_pkg::encode_cp({5'd0, held_ff});
   assign unit_enc  = jsu_pkg::encode_cp({5'd0, acc_new});
   assign pair_enc  = jsu_pkg::encode_cp(pair_cp);
   assign byte_enc  = one_byte(in_byte);
   assign esc_enc   = one_byte(esc.value);
   assign mode      = mode_ff;

   // Next state.
   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      held_in = held_ff;
      if (!mode_active || in_end) begin
         mode_in = jsu_pkg::MODE_IDLE;
         acc_in  = '0;
         cnt_in  = '0;
         held_in = '0;
         if (!mode_active && !in_end && in_byte == jsu_pkg::CHAR_QUOTE) begin
            mode_in = jsu_pkg::MODE_STR;
         end
      end else begin
         unique case (mode_ff)
            jsu_pkg::MODE_STR: begin
               if (in_byte == jsu_pkg::CHAR_QUOTE) begin
                  mode_in = jsu_pkg::MODE_IDLE;
               end else if (in_byte == jsu_pkg::CHAR_BSLASH) begin
                  mode_in = jsu_pkg::MODE_ESC;
               end
            end
            jsu_pkg::MODE_ESC, jsu_pkg::MODE_HELD_ESC: begin
               if (in_byte == jsu_pkg::CHAR_U) begin
                  mode_in = (mode_ff == jsu_pkg::MODE_ESC) ? jsu_pkg::MODE_HEX
                                                          : jsu_pkg::MODE_HELD_HEX;
                  acc_in  = '0;
                  cnt_in  = '0;
               end else if (esc.valid) begin
                  mode_in = jsu_pkg::MODE_STR;
               end else begin
                  mode_in = jsu_pkg::MODE_IDLE;
                  held_in = '0;
               end
            end
            jsu_pkg::MODE_HEX, jsu_pkg::MODE_HELD_HEX: begin
               if (!hex.valid) begin
                  mode_in = jsu_pkg::MODE_IDLE;
                  acc_in  = '0;
                  cnt_in  = '0;
                  held_in = '0;
               end else begin
                  acc_in = acc_new;
                  if (hex_last) begin
                     cnt_in = '0;
                     // A joined pair never holds; any other high surrogate does.
                     if (unit_high && !(mode_ff == jsu_pkg::MODE_HELD_HEX && unit_low)) begin
                        held_in = acc_new;
                        mode_in = jsu_pkg::MODE_HELD;
                     end else begin
                        mode_in = jsu_pkg::MODE_STR;
                     end
                  end else begin
                     cnt_in = cnt_ff + 2'd1;
                  end
               end
            end
            jsu_pkg::MODE_HELD: begin
               if (in_byte == jsu_pkg::CHAR_BSLASH) begin
                  mode_in = jsu_pkg::MODE_HELD_ESC;
               end else if (in_byte == jsu_pkg::CHAR_QUOTE) begin
                  mode_in = jsu_pkg::MODE_IDLE;
                  held_in = '0;
               end else begin
                  mode_in = jsu_pkg::MODE_STR;
               end
            end
            default: begin
               mode_in = jsu_pkg::MODE_IDLE;
            end
         endcase
      end
   end

   // Results of the current byte.
   always_comb begin
      logic fail;
      logic done;
      fail = 1'b0;
      done = 1'b0;
      run  = '0;
      if (mode_active) begin
         if (in_end) begin
            fail = 1'b1;
         end else begin
            unique case (mode_ff)
               jsu_pkg::MODE_STR: begin
                  if (in_byte == jsu_pkg::CHAR_QUOTE) begin
                     done = 1'b1;
                  end else if (in_byte != jsu_pkg::CHAR_BSLASH) begin
                     run = append_seq(run, byte_enc);
                  end
               end
               jsu_pkg::MODE_ESC, jsu_pkg::MODE_HELD_ESC: begin
                  if (in_byte != jsu_pkg::CHAR_U) begin
                     if (mode_ff == jsu_pkg::MODE_HELD_ESC) begin
                        run = append_seq(run, held_enc);
                     end
                     if (esc.valid) begin
                        run = append_seq(run, esc_enc);
                     end else begin
                        fail = 1'b1;
                     end
                  end
               end
               jsu_pkg::MODE_HEX: begin
                  if (!hex.valid) begin
                     fail = 1'b1;
                  end else if (hex_last && !unit_high) begin
                     run = append_seq(run, unit_enc);
                  end
               end
               jsu_pkg::MODE_HELD: begin
                  if (in_byte != jsu_pkg::CHAR_BSLASH) begin
                     run = append_seq(run, held_enc);
                     if (in_byte == jsu_pkg::CHAR_QUOTE) begin
                        done = 1'b1;
                     end else begin
                        run = append_seq(run, byte_enc);
                     end
                  end
               end
               jsu_pkg::MODE_HELD_HEX: begin
                  if (!hex.valid) begin
                     fail = 1'b1;
                  end else if (hex_last) begin
                     if (unit_low) begin
                        run = append_seq(run, pair_enc);
                     end else begin
                        run = append_seq(run, held_enc);
                        if (!unit_high) begin
                           run = append_seq(run, unit_enc);
                        end
                     end
                  end
               end
               default: begin
                  run = '0;
               end
            endcase
         end
      end
      if (fail) begin
         // Anything gathered for this byte is dropped in favor of the error.
         run           = '0;
         run.status[0] = jsu_pkg::STATUS_ERROR;
         run.count     = jsu_pkg::RUN_CNT_W'(1);
      end else if (done) begin
         run.data[run.count]   = 8'h00;
         run.status[run.count] = jsu_pkg::STATUS_DONE;
         run.count             = run.count + jsu_pkg::RUN_CNT_W'(1);
      end
   end

   assign run_valid = in_valid && (run.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jsu_pkg::MODE_IDLE;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         held_ff <= '0;
      end else if (in_valid) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         held_ff <= held_in;
      end
   end

endmodule

@@ rtl/core/jsu_queue.sv @@
`timescale 1ns / 1ps
// Short queue of result runs between the decoder front end and the drain.
// Uses jsu_pkg for the run type.
module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::run_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output jsu_pkg::run_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_pkg::run_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ rtl/core/jsu_back.sv @@
`timescale 1ns / 1ps
// Back end of the JSON string decoder: walks the run at the head of the
// queue and presents its results one per transfer. Uses jsu_pkg.
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  jsu_pkg::run_type head,
   input  logic             head_empty,
   output logic             head_pop,
   input  logic             pop,
   output logic [7:0]       out_byte,
   output logic [1:0]       status,
   output logic             last_of_run
);

   logic [jsu_pkg::RUN_CNT_W-1:0] idx_ff, idx_in;
   logic                          take;

   assign out_byte    = head.data[idx_ff];
   assign status      = head.status[idx_ff];
   assign last_of_run = (idx_ff == head.count - jsu_pkg::RUN_CNT_W'(1));
   assign take        = pop && !head_empty;
   assign head_pop    = take && last_of_run;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last_of_run ? '0 : idx_ff + jsu_pkg::RUN_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

@@ rtl/core/json_string_unescape_utf8.sv @@
`timescale 1ns / 1ps
// Top level of the JSON string decoder: front end, run queue and drain.
// Uses jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
//   channel   handshake      payload
//   request   push / full    req_in_byte, req_end_marker
//   response  pop / empty    rsp_out_byte, rsp_status, rsp_last_of_run
//
// One byte is taken per cycle while full is low; its results, if any, are
// written to the run queue at the same edge. The drain sends one result per
// cycle while pop is high and the queue is not empty, so a run holds its slot
// until all of its results are sent, and full rises only once QUEUE_DEPTH
// runs are waiting. Reset is synchronous and clears the queue and the string
// state; no clearing pass is needed.
module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_marker,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last_of_run
);

   logic              in_accept;
   logic              run_valid;
   jsu_pkg::run_type  run;
   jsu_pkg::mode_type mode;
   jsu_pkg::run_type  head;
   logic              head_pop;

   assign in_accept = push && !full;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_accept),
      .in_byte   (req_in_byte),
      .in_end    (req_end_marker),
      .run_valid (run_valid),
      .run       (run),
      .mode      (mode)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (run_valid),
      .push_data (run),
      .full      (full),
      .pop       (head_pop),
      .empty     (empty),
      .head      (head)
   );

   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_empty  (empty),
      .head_pop    (head_pop),
      .pop         (pop),
      .out_byte    (rsp_out_byte),
      .status      (rsp_status),
      .last_of_run (rsp_last_of_run)
   );

   // A done or error result always closes its run and carries no byte.
   a_status_closes_run: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != jsu_pkg::STATUS_BYTE) |->
         (rsp_last_of_run && rsp_out_byte == 8'h00))
      else $error("done or error result not last of its run");

   // A run that ends in done or error leaves the front end idle.
   a_close_to_idle: assert property (@(posedge clock) disable iff (reset)
      (run_valid && run.status[run.count - jsu_pkg::RUN_CNT_W'(1)] != jsu_pkg::STATUS_BYTE)
         |=> (mode == jsu_pkg::MODE_IDLE))
      else $error("front end not idle after closing a string");

   // Reset leaves no stale results.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (empty && mode == jsu_pkg::MODE_IDLE))
      else $error("queue or front end not cleared by reset");

endmodule
